/* hdl/cht_pkg.sv */
// package for the chained hash table engine
// holds command and status codes, widths and defaults; no dependencies
package cht_pkg;

  localparam int unsigned BUCKETS_DEF       = 256;
  localparam int unsigned ENTRIES_DEF       = 256;
  localparam int unsigned MAX_KEY_BYTES_DEF = 8;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned KLEN_W  = 4;
  localparam int unsigned CFG_W   = 32;

  localparam logic [31:0] SEED_RESET = 32'd5381;
  localparam logic [3:0]  KLEN_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_GET = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic {
    REG_SEED = 1'b0,
    REG_KLEN = 1'b1
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input, start hash
    logic hash_step;   // one byte of hash
    logic head_rd;     // read bucket head
    logic head_take;   // cur <= head
    logic ent_rd;      // read entry at cur
    logic ent_adv;     // prev <= cur, cur <= link
    logic free_rd;     // read free stack top
    logic do_add;      // write new entry and head
    logic do_del;      // unlink cur, push free
    logic clr_step;    // clearing pass step
    logic result;      // load output register
    logic res_hit;
  } cht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic cur_nil;
    logic key_eq;
    logic full;
    logic walk_over;
    logic clr_done;
    cmd_t cmd;
  } cht_stat_t;

endpackage

/* hdl/cht_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cht_datapath.sv */
// datapath: hash unit, table memories, chain pointers, free stack, output register
// depends on cht_pkg and cht_ram
module cht_datapath #(
  parameter int unsigned BUCKETS       = cht_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES       = cht_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_KEY_BYTES = cht_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cht_pkg::cht_cmd_t         ctl,
  output cht_pkg::cht_stat_t        stat,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [cht_pkg::CFG_W-1:0] cfg_data,
  input  logic [1:0]                in_cmd,
  input  logic [cht_pkg::KEY_W-1:0] in_key,
  input  logic [31:0]               in_value,
  output logic [1:0]                out_status,
  output logic [31:0]               out_found,
  output logic [$clog2(ENTRIES):0]  out_count
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned LW = EW + 1;
  localparam int unsigned KB = MAX_KEY_BYTES;
  localparam int unsigned KBW = (KB > 1) ? $clog2(KB + 1) : 2;
  localparam int unsigned CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int unsigned CLRW = $clog2(CLR_N) + 1;

  logic [31:0]    hash_seed;
  logic [3:0]     key_length;
  logic [KBW-1:0] eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed  <= cht_pkg::SEED_RESET;
      key_length <= cht_pkg::KLEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cht_pkg::REG_SEED) hash_seed <= cfg_data;
      else key_length <= cfg_data[3:0];
    end
  end

  always_comb begin
    if (key_length == 4'd0) eff_len = KBW'(1);
    else if (32'(key_length) > KB) eff_len = KBW'(KB);
    else eff_len = KBW'(key_length);
  end

  logic [cht_pkg::KEY_W-1:0] key_mask;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_mask[i*8 +: 8] = (i < 32'(eff_len)) ? 8'hff : 8'h00;
    end
  end

  cht_pkg::cmd_t             cmd;
  logic [cht_pkg::KEY_W-1:0] key;
  logic [31:0]               value;
  logic [31:0]               hash;
  logic [KBW-1:0]            byte_idx;
  logic [LW-1:0]             cur;
  logic [LW-1:0]             prev;
  logic [LW-1:0]             steps;
  logic [LW-1:0]             used;
  logic [BW-1:0]             bucket;
  logic [CLRW-1:0]           clr_idx;
  logic [7:0]                cur_byte;
  logic                      added;

  assign bucket   = hash[BW-1:0];
  assign cur_byte = 8'(key >> (32'(byte_idx) * 8));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd      <= cht_pkg::cmd_t'(in_cmd);
      key      <= in_key & key_mask;
      value    <= in_value;
      hash     <= hash_seed;
      byte_idx <= '0;
    end else if (ctl.hash_step) begin
      hash     <= (hash << 5) + hash + 32'(cur_byte);
      byte_idx <= byte_idx + KBW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) added <= 1'b0;
    else if (ctl.do_add) added <= 1'b1;
  end

  // bucket heads: ram set to nil by a clearing pass after reset
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd;
  logic [LW-1:0] head_rd;
  logic [EW-1:0] ent_idx;
  logic [cht_pkg::KEY_W-1:0] ek_rd;
  logic [31:0]   ev_rd;
  logic [LW-1:0] el_rd;
  logic [EW-1:0] fs_rd;
  logic          fs_we;
  logic [EW-1:0] fs_wa;
  logic [EW-1:0] fs_wd;
  logic [EW-1:0] fs_ra;
  logic          link_we;
  logic [EW-1:0] link_wa;
  logic [LW-1:0] link_wd;
  logic [EW-1:0] new_e;

  assign new_e = fs_rd;
  assign fs_ra = EW'(ENTRIES - 1) - used[EW-1:0];

  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = '0;
    fs_we   = 1'b0;
    fs_wa   = '0;
    fs_wd   = '0;
    link_we = 1'b0;
    link_wa = new_e;
    link_wd = head_rd;
    if (ctl.clr_step) begin
      head_we = 1'b1;
      head_wa = clr_idx[BW-1:0];
      head_wd = LW'(ENTRIES);
      fs_we   = (32'(clr_idx) < ENTRIES);
      fs_wa   = clr_idx[EW-1:0];
      fs_wd   = clr_idx[EW-1:0];
    end else if (ctl.do_add) begin
      head_we = 1'b1;
      head_wd = LW'(new_e);
      link_we = 1'b1;
    end else if (ctl.do_del) begin
      link_wd = el_rd;
      if (prev[EW]) begin
        head_we = 1'b1;
        head_wd = el_rd;
      end else begin
        link_we = 1'b1;
        link_wa = prev[EW-1:0];
      end
      fs_we = 1'b1;
      fs_wa = EW'(ENTRIES) - used[EW-1:0];
      fs_wd = cur[EW-1:0];
    end
  end

  assign ent_idx = cur[EW-1:0];

  cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(bucket), .rdata(head_rd)
  );
  cht_ram #(.WIDTH(cht_pkg::KEY_W), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(ctl.do_add), .waddr(new_e), .wdata(key),
    .raddr(ent_idx), .rdata(ek_rd)
  );
  cht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_vals (
    .clk(clk), .we(ctl.do_add), .waddr(new_e), .wdata(value),
    .raddr(ent_idx), .rdata(ev_rd)
  );
  cht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(ent_idx), .rdata(el_rd)
  );
  cht_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
    .raddr(fs_ra), .rdata(fs_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      clr_idx <= '0;
    end else begin
      if (ctl.clr_step) clr_idx <= clr_idx + CLRW'(1);
      if (ctl.do_add) used <= used + LW'(1);
      else if (ctl.do_del && used != '0) used <= used - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.head_take) begin
      cur   <= head_rd;
      prev  <= LW'(ENTRIES);
      steps <= '0;
    end else if (ctl.ent_adv) begin
      prev  <= cur;
      cur   <= el_rd;
      steps <= steps + LW'(1);
    end
  end

  // an insert has already updated used when the result is loaded
  always_ff @(posedge clk) begin
    if (ctl.result) begin
      out_found <= ctl.res_hit && (cmd == cht_pkg::CMD_DEL || cmd == cht_pkg::CMD_GET)
                   ? ev_rd : 32'd0;
      if (cmd == cht_pkg::CMD_ADD) begin
        if (ctl.res_hit) out_status <= cht_pkg::ST_MISS;
        else if (added) out_status <= cht_pkg::ST_OK;
        else out_status <= cht_pkg::ST_FULL;
      end else if (cmd == cht_pkg::CMD_NOP) begin
        out_status <= cht_pkg::ST_MISS;
      end else begin
        out_status <= ctl.res_hit ? cht_pkg::ST_OK : cht_pkg::ST_MISS;
      end
      // count after the operation
      if (cmd == cht_pkg::CMD_DEL && ctl.res_hit && used != '0)
        out_count <= used - LW'(1);
      else
        out_count <= used;
    end
  end

  assign stat.hash_done = (byte_idx == eff_len);
  assign stat.cur_nil   = cur[EW];
  assign stat.key_eq    = (ek_rd == key);
  assign stat.full      = (32'(used) >= ENTRIES);
  assign stat.walk_over = (32'(steps) >= ENTRIES);
  assign stat.clr_done  = (32'(clr_idx) >= CLR_N - 1);
  assign stat.cmd       = cmd;

endmodule

/* hdl/cht_ctrl.sv */
// controller state machine sequencing hash, chain walk and update
// depends on cht_pkg
module cht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cht_pkg::cht_cmd_t  ctl,
  input  cht_pkg::cht_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_TAKE, S_ENT_RD, S_CHECK,
    S_FREE_RD, S_ADD, S_RESULT, S_DONE
  } state_t;

  state_t state;
  logic   hit;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    ctl = '0;
    ctl.res_hit = hit;
    unique case (state)
      S_CLEAR:     ctl.clr_step  = 1'b1;
      S_IDLE:      ctl.load      = in_valid && in_ready;
      S_HASH:      ctl.hash_step = !stat.hash_done;
      S_HEAD_RD:   ctl.head_rd   = 1'b1;
      S_HEAD_TAKE: ctl.head_take = 1'b1;
      S_ENT_RD:    ctl.ent_rd    = 1'b1;
      S_CHECK:     ctl.ent_adv   = !stat.key_eq;
      S_FREE_RD:   ctl.free_rd   = 1'b1;
      S_ADD:       ctl.do_add    = 1'b1;
      S_RESULT: begin
        ctl.result = 1'b1;
        ctl.do_del = hit && (stat.cmd == cht_pkg::CMD_DEL);
      end
      S_DONE:      ctl = ctl;
      default:     ctl = ctl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR:     if (stat.clr_done) state <= S_IDLE;
        S_IDLE:      if (in_valid && in_ready) state <= S_HASH;
        S_HASH:      if (stat.hash_done) state <= S_HEAD_RD;
        S_HEAD_RD:   state <= S_HEAD_TAKE;
        S_HEAD_TAKE: begin
          hit   <= 1'b0;
          state <= S_ENT_RD;
        end
        S_ENT_RD: begin
          if (stat.cur_nil || stat.walk_over) begin
            if (stat.cmd == cht_pkg::CMD_ADD && !stat.full) state <= S_FREE_RD;
            else state <= S_RESULT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.key_eq) begin
            hit   <= 1'b1;
            state <= S_RESULT;
          end else begin
            state <= S_ENT_RD;
          end
        end
        S_FREE_RD:   state <= S_ADD;
        S_ADD:       state <= S_RESULT;
        S_RESULT: begin
          out_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE:      state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/chained_hash_table_engine.sv */
// top level of the chained hash table engine
// depends on cht_pkg, cht_ctrl, cht_datapath
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata: command, key, value
// m_axis   out  m_axis_tvalid/tready    tdata: status, found_value, entry_count
// cfg      in   cfg_we                  cfg_index, cfg_data
//
// an operation hashes the key one byte at a time, then walks the bucket's chain one entry
// at a time, reading each entry from the single-read-port entry memories; an insert then
// also reads the free stack and writes the new entry and the bucket head.
// after reset a clearing pass over max(BUCKETS, ENTRIES) addresses runs before input is taken.
// a result stays in the output register until taken; the next input waits for it.
module chained_hash_table_engine #(
  parameter int unsigned BUCKETS       = cht_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES       = cht_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_KEY_BYTES = cht_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [103:0]              s_axis_tdata,  // command, key, value, pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,  // status, found_value, entry_count, pad
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [cht_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(ENTRIES) + 1;

  cht_pkg::cht_cmd_t  ctl;
  cht_pkg::cht_stat_t stat;
  logic [1:0]         out_status;
  logic [31:0]        out_found;
  logic [CW-1:0]      out_count;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .ctl(ctl), .stat(stat)
  );

  cht_datapath #(
    .BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cmd(s_axis_tdata[1:0]), .in_key(s_axis_tdata[65:2]),
    .in_value(s_axis_tdata[97:66]),
    .out_status(out_status), .out_found(out_found), .out_count(out_count)
  );

  assign m_axis_tdata = {5'd0, 9'(out_count), out_found, out_status};

endmodule

/* hdl/cht_checker.sv */
// port-level checker for the chained hash table engine
// depends on chained_hash_table_engine ports
module cht_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status");

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
